// ===== rtl/core/padc_pkg.sv =====
// Shared types and constants for the parallel converter capture sequencer.
// No dependencies; imported by padc_seq, padc_cfg and the top level.
`default_nettype none

package padc_pkg;

  localparam int Channels = 8;

  localparam int DataW    = 16;
  localparam int TpuW     = 10;
  localparam int TimeoutW = 16;
  localparam int OsW      = 3;
  localparam int ChanW    = 3;
  localparam int DelayW   = 12;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [TpuW-1:0]     TpuReset     = 10'd100;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd50000;
  localparam logic [OsW-1:0]      OsInvalid    = 3'd7;
  localparam logic [ChanW-1:0]    ChanLast     = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_US  = 2'd0,
    CFG_TIMEOUT_LIMIT = 2'd1,
    CFG_OS_RATIO      = 2'd2,
    CFG_RANGE_10V     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUSY_TMO  = 2'd1,
    ST_FIRST_TMO = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_HI, PH_RST_LO, PH_CA_PRE, PH_CA_LO, PH_CB_PRE, PH_CB_LO,
    PH_CONV_END, PH_BUSY_WAIT, PH_CS_LOW, PH_RD_SETTLE, PH_FRST_WAIT,
    PH_GAP, PH_RD_ACT, PH_HOLD
  } phase_e;

  typedef struct packed {
    logic [TpuW-1:0]     ticks_per_us;
    logic [TimeoutW-1:0] timeout_limit;
    logic [OsW-1:0]      os_ratio;
    logic                range_10v;
  } cfg_t;

  typedef struct packed {
    logic             cs_n;
    logic             rd_n;
    logic             conv_a_n;
    logic             conv_b_n;
    logic             adc_reset;
    logic [OsW-1:0]   os_pins;
    logic             range_pin;
    logic [DataW-1:0] sample_value;
    logic [ChanW-1:0] channel;
    logic             sample_valid;
    logic             done_res;
    status_e          status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/padc_seq.sv =====
// Capture sequencer state machine: phase, delay and wait counters, channel index.
// Depends on padc_pkg; advances one tick per accepted request.
`default_nettype none

module padc_seq (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire padc_pkg::cfg_t         cfg_i,
  input  wire logic                   start_req_i,
  input  wire logic                   busy_req_i,
  input  wire logic                   first_data_i,
  input  wire logic [15:0]            data_bus_i,
  output padc_pkg::res_t              res_o
);
  import padc_pkg::*;

  phase_e              phase_q, phase_d;
  logic [DelayW-1:0]   delay_q, delay_d;
  logic [TimeoutW-1:0] wait_q, wait_d;
  logic [ChanW-1:0]    chan_q, chan_d;
  logic                rst_done_q, rst_done_d;

  logic [TpuW-1:0]     tpu;
  logic                two_units;
  logic [TpuW:0]       dly_len;
  logic                dly_last;
  logic                wait_tmo;
  logic                last_chan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      delay_q    <= '0;
      wait_q     <= '0;
      chan_q     <= '0;
      rst_done_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      delay_q    <= delay_d;
      wait_q     <= wait_d;
      chan_q     <= chan_d;
      rst_done_q <= rst_done_d;
    end
  end

  // Delay length in ticks: one or two microsecond units, zero rate reads as one.
  always_comb begin
    tpu       = (cfg_i.ticks_per_us == '0) ? TpuW'(1) : cfg_i.ticks_per_us;
    two_units = (phase_q == PH_RD_SETTLE) || (phase_q == PH_GAP) || (phase_q == PH_HOLD);
    dly_len   = two_units ? {tpu, 1'b0} : {1'b0, tpu};
    dly_last  = ({1'b0, delay_q} + 13'd1) >= {2'b00, dly_len};
    wait_tmo  = wait_q >= cfg_i.timeout_limit;
    last_chan = (({1'b0, chan_q} + 4'd1) >= 4'(Channels)) || (chan_q == ChanLast);
  end

  always_comb begin
    phase_d    = phase_q;
    delay_d    = dly_last ? '0 : delay_q + DelayW'(1);
    wait_d     = wait_q;
    chan_d     = chan_q;
    rst_done_d = rst_done_q;

    res_o              = '0;
    res_o.cs_n         = !(phase_q >= PH_CS_LOW);
    res_o.rd_n         = !((phase_q == PH_RD_SETTLE) || (phase_q == PH_FRST_WAIT) ||
                           (phase_q == PH_RD_ACT) || (phase_q == PH_HOLD));
    res_o.conv_a_n     = (phase_q != PH_CA_LO);
    res_o.conv_b_n     = (phase_q != PH_CB_LO);
    res_o.adc_reset    = (phase_q == PH_RST_HI);
    res_o.os_pins      = (cfg_i.os_ratio == OsInvalid) ? '0 : cfg_i.os_ratio;
    res_o.range_pin    = cfg_i.range_10v;
    res_o.status       = ST_OK;

    case (phase_q)
      PH_IDLE: begin
        delay_d = delay_q;
        if (start_req_i) begin
          chan_d  = '0;
          delay_d = '0;
          wait_d  = '0;
          if (!rst_done_q) begin
            rst_done_d = 1'b1;
            phase_d    = PH_RST_HI;
          end else begin
            phase_d = PH_CA_PRE;
          end
        end
      end
      PH_RST_HI:    if (dly_last) phase_d = PH_RST_LO;
      PH_RST_LO:    if (dly_last) phase_d = PH_CA_PRE;
      PH_CA_PRE:    if (dly_last) phase_d = PH_CA_LO;
      PH_CA_LO:     if (dly_last) phase_d = PH_CB_PRE;
      PH_CB_PRE:    if (dly_last) phase_d = PH_CB_LO;
      PH_CB_LO:     if (dly_last) phase_d = PH_CONV_END;
      PH_CONV_END: begin
        if (dly_last) begin
          phase_d = PH_BUSY_WAIT;
          wait_d  = '0;
        end
      end
      PH_BUSY_WAIT: begin
        delay_d = '0;
        if (!busy_req_i) begin
          phase_d = PH_CS_LOW;
          wait_d  = '0;
        end else if (wait_tmo) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_BUSY_TMO;
          phase_d        = PH_IDLE;
          wait_d         = '0;
        end else begin
          wait_d = wait_q + TimeoutW'(1);
        end
      end
      PH_CS_LOW:    if (dly_last) phase_d = PH_RD_SETTLE;
      PH_RD_SETTLE: begin
        if (dly_last) begin
          phase_d = PH_FRST_WAIT;
          wait_d  = '0;
        end
      end
      PH_FRST_WAIT: begin
        delay_d = '0;
        if (first_data_i) begin
          res_o.sample_valid = 1'b1;
          res_o.sample_value = data_bus_i;
          chan_d             = ChanW'(1);
          wait_d             = '0;
          if (Channels <= 1) begin
            res_o.done_res = 1'b1;
            phase_d        = PH_IDLE;
          end else begin
            phase_d = PH_GAP;
          end
        end else if (wait_tmo) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_FIRST_TMO;
          phase_d        = PH_IDLE;
          wait_d         = '0;
        end else begin
          wait_d = wait_q + TimeoutW'(1);
        end
      end
      PH_GAP:       if (dly_last) phase_d = PH_RD_ACT;
      PH_RD_ACT: begin
        if (dly_last) begin
          res_o.sample_valid = 1'b1;
          res_o.sample_value = data_bus_i;
          res_o.channel      = chan_q;
          phase_d            = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (dly_last) begin
          if (last_chan) begin
            res_o.done_res = 1'b1;
            phase_d        = PH_IDLE;
          end else begin
            chan_d  = chan_q + ChanW'(1);
            phase_d = PH_GAP;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        delay_d = '0;
        wait_d  = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/padc_cfg.sv =====
// Configuration register file for the capture sequencer (write-only port).
// Depends on padc_pkg for register indexes, widths and reset values.
`default_nettype none

module padc_cfg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_idx_i,
  input  wire logic [15:0]              cfg_data_i,
  output padc_pkg::cfg_t                cfg_o
);
  import padc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TICKS_PER_US:  cfg_d.ticks_per_us  = cfg_data_i[TpuW-1:0];
        CFG_TIMEOUT_LIMIT: cfg_d.timeout_limit = cfg_data_i[TimeoutW-1:0];
        CFG_OS_RATIO:      cfg_d.os_ratio      = cfg_data_i[OsW-1:0];
        CFG_RANGE_10V:     cfg_d.range_10v     = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_us  <= TpuReset;
      cfg_q.timeout_limit <= TimeoutReset;
      cfg_q.os_ratio      <= '0;
      cfg_q.range_10v     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/parallel_adc_capture_sequencer_unit.sv =====
// Top level of the parallel converter capture sequencer.
// Depends on padc_pkg, padc_cfg and padc_seq.
//
// Usage:
//   Each request on the input channel is one tick of the converter bus: a
//   start request plus the sampled busy, first-data and 16-bit data pins.
//   Every request yields exactly one result on the output channel with the
//   pin drives for that tick and, where one is taken, a captured sample with
//   its channel number, plus done and status at the end of a sequence.
//   A result appears in the cycle after its request is accepted; one request is
//   taken every cycle unless stalled, set by the single sequencer step between
//   the request and the result register. The next request is taken while a
//   result is still waiting, as long as that result is taken in the same cycle.
//   When the receiver stalls with a result held, input stall rises, the
//   result holds and the sequencer state holds.
//   Reset clears the sequencer to idle with the converter reset pulse still
//   pending, empties the result register and loads the register defaults
//   (100 ticks per microsecond, timeout 50000, oversampling 0, 5 V range).
//   Write configuration only while no sequence is running.
`default_nettype none

module parallel_adc_capture_sequencer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        start_req_i,
  input  wire logic        busy_req_i,
  input  wire logic        first_data_i,
  input  wire logic [15:0] data_bus_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             cs_n_o,
  output logic             rd_n_o,
  output logic             conv_a_n_o,
  output logic             conv_b_n_o,
  output logic             adc_reset_o,
  output logic [2:0]       os_pins_o,
  output logic             range_pin_o,
  output logic [15:0]      sample_value_o,
  output logic [2:0]       channel_o,
  output logic             sample_valid_o,
  output logic             done_res_o,
  output logic [1:0]       status_o
);
  import padc_pkg::*;

  cfg_t cfg;
  res_t res_d, res_q;
  logic out_valid_q, out_valid_d;
  logic accept;

  padc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stall only when the result register is full and the receiver holds it.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  padc_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .cfg_i        (cfg),
    .start_req_i  (start_req_i),
    .busy_req_i   (busy_req_i),
    .first_data_i (first_data_i),
    .data_bus_i   (data_bus_i),
    .res_o        (res_d)
  );

  // Result register: load on every accepted request, hold while stalled.
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cs_n_o         = res_q.cs_n;
  assign rd_n_o         = res_q.rd_n;
  assign conv_a_n_o     = res_q.conv_a_n;
  assign conv_b_n_o     = res_q.conv_b_n;
  assign adc_reset_o    = res_q.adc_reset;
  assign os_pins_o      = res_q.os_pins;
  assign range_pin_o    = res_q.range_pin;
  assign sample_value_o = res_q.sample_value;
  assign channel_o      = res_q.channel;
  assign sample_valid_o = res_q.sample_valid;
  assign done_res_o     = res_q.done_res;
  assign status_o       = res_q.status;

  // A capture happens only with chip select and read both asserted.
  a_capture_on_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o |-> !cs_n_o && !rd_n_o)
    else $error("capture reported outside an active read");

  // An error status is only ever reported on the closing tick.
  a_status_with_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> done_res_o && !sample_valid_o)
    else $error("error status without done");

  // Conversion and reset strobes never overlap the bus read window.
  a_strobes_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cs_n_o |-> conv_a_n_o && conv_b_n_o && !adc_reset_o)
    else $error("strobe asserted while chip select is low");

  // Results never appear without a request in the previous cycle or a hold.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without an accepted request");

endmodule

`default_nettype wire
